// ----- rtl/moving_average_with_refill_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the moving average unit
// Concurrent checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_WITH_REFILL_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_WITH_REFILL_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MAWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MAWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MAWR_ASSERT(lbl, prop, msg)
`define MAWR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mawr_pkg.sv -----
// ----------------------------------------------------------------------------
// mawr_pkg
// Shared constants and controller interface types of the moving average unit.
// ----------------------------------------------------------------------------
package mawr_pkg;

  localparam int          MAX_WINDOW_DEF = 64;
  localparam int          SAMPLE_W       = 16;
  localparam int          CFG_W          = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd50;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// ----- rtl/moving_average_with_refill_unit.sv -----
// ----------------------------------------------------------------------------
// moving_average_with_refill_unit
// Boxcar moving average of signed Q1.15 samples with whole-window refill.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one sample and a restart flag.
// The unit answers each request with one result: the mean of the newest
// window_length samples, truncated toward zero. A restart request makes all
// store entries read as its sample, so its mean equals that sample.
// The window length must be written through cfg_wr_en and cfg_wr_data only
// while the unit is idle; the unit does not enforce this. Zero acts as one
// and values above MAX_WINDOW act as MAX_WINDOW.
// One request is processed at a time. The store is read one entry per
// cycle over the window, then a restoring divider produces one quotient
// bit per cycle. The next request is accepted in the cycle after the
// result is loaded. The result register holds while out_stall is high;
// a finished division waits for it before loading. Reset makes every
// store entry read as zero and sets the window length to 50.
// ----------------------------------------------------------------------------
module moving_average_with_refill_unit #(
  parameter int MAX_WINDOW = mawr_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [mawr_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_restart,
  input  logic signed [mawr_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mawr_pkg::SAMPLE_W-1:0] out_mean
);
  import mawr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mawr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mawr_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_restart  (in_restart),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_mean    (out_mean)
  );

endmodule

// ----- rtl/mawr_ram.sv -----
// ----------------------------------------------------------------------------
// mawr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mawr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mawr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mawr_ctrl
// Sequencer of the moving average unit: accept, window walk, divide, output.
// ----------------------------------------------------------------------------
`include "moving_average_with_refill_unit_assert.svh"

module mawr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mawr_pkg::ctrl_sts_t  sts,
  output mawr_pkg::ctrl_cmd_t  cmd
);
  import mawr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_FLUSH = 6'b000100,
    S_PREP  = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        cmd.rd_issue = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `MAWR_ASSERT_NEXT(a_accept_walks, in_valid && !in_stall, state_r == S_WALK, "Accepted request did not start the window walk.")
  `MAWR_ASSERT_NEXT(a_walk_ends, state_r == S_WALK && sts.walk_last, state_r == S_FLUSH, "Window walk did not end after its last read.")
  `MAWR_ASSERT(a_load_free, cmd.out_load |-> !sts.out_busy, "Result loaded over a stalled result.")

endmodule

// ----- rtl/mawr_dp.sv -----
// ----------------------------------------------------------------------------
// mawr_dp
// Datapath: sample store, window accumulator and bit-serial divider.
// ----------------------------------------------------------------------------
`include "moving_average_with_refill_unit_assert.svh"

module mawr_dp #(
  parameter int MAX_WINDOW = mawr_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mawr_pkg::ctrl_cmd_t                 cmd,
  output mawr_pkg::ctrl_sts_t                 sts,
  input  logic                                cfg_wr_en,
  input  logic [mawr_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_restart,
  input  logic signed [mawr_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mawr_pkg::SAMPLE_W-1:0] out_mean
);
  import mawr_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_WINDOW - 1);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_WINDOW);
  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(SUM_W - 1);

  logic [CFG_W-1:0]           wl_r;
  logic [ADDR_W-1:0]          pos_r, pos_nxt;
  logic [LEN_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] fill_r;
  logic [LEN_W-1:0]           len_r, len_eff;
  logic [ADDR_W-1:0]          rd_addr_r;
  logic [LEN_W-1:0]           k_r;
  logic                       rd_pend_r;
  logic                       hit_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] term;
  logic                       neg_r;
  logic [SUM_W-1:0]           mag_r;
  logic [LEN_W-1:0]           rem_r;
  logic [LEN_W:0]             trial;
  logic                       trial_ge;
  logic [DCNT_W-1:0]          dcnt_r;
  logic [SAMPLE_W:0]          quot;
  logic [SAMPLE_W:0]          quot_signed;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_mean_r;

  always_comb begin
    if (wl_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(wl_r) > MAX_WINDOW) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LEN_W'(wl_r);
    end
  end

  assign pos_nxt = (pos_r == LAST_ADDR) ? '0 : pos_r + ADDR_W'(1);

  mawr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.capture),
    .wr_addr (pos_nxt),
    .wr_data (in_sample),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Entries not written since the last refill read as the refill sample.
  assign term     = hit_r ? rd_data : fill_r;
  assign trial    = {rem_r, mag_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, len_r});
  assign quot     = mag_r[SAMPLE_W:0];
  assign quot_signed = neg_r ? (~quot + (SAMPLE_W+1)'(1)) : quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= WINDOW_RESET;
      pos_r       <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wl_r <= cfg_wr_data;
      end
      rd_pend_r <= cmd.rd_issue;
      if (cmd.capture) begin
        pos_r <= pos_nxt;
        if (in_restart) begin
          fill_r <= in_sample;
          cnt_r  <= LEN_W'(1);
        end else if (cnt_r != MAX_LEN) begin
          cnt_r <= cnt_r + LEN_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len_r     <= len_eff;
      rd_addr_r <= pos_nxt;
      k_r       <= '0;
      acc_r     <= '0;
    end
    if (cmd.rd_issue) begin
      rd_addr_r <= (rd_addr_r == '0) ? LAST_ADDR : rd_addr_r - ADDR_W'(1);
      k_r       <= k_r + LEN_W'(1);
      hit_r     <= (k_r < cnt_r);
    end
    if (rd_pend_r) begin
      acc_r <= acc_r + SUM_W'(term);
    end
    if (cmd.div_init) begin
      neg_r  <= acc_r[SUM_W-1];
      mag_r  <= acc_r[SUM_W-1] ? (~acc_r + SUM_W'(1)) : acc_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_ge ? LEN_W'(trial - {1'b0, len_r}) : LEN_W'(trial);
      mag_r  <= {mag_r[SUM_W-2:0], trial_ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_mean_r <= quot_signed[SAMPLE_W-1:0];
    end
  end

  assign sts.walk_last = (k_r == len_r - LEN_W'(1));
  assign sts.div_last  = (dcnt_r == DIV_LAST);
  assign sts.out_busy  = out_valid_r & out_stall;

  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;

  `MAWR_ASSERT(a_acc_done, cmd.div_init |-> !rd_pend_r, "Division started before the last sample was summed.")
  `MAWR_ASSERT(a_cnt_range, cnt_r <= MAX_LEN, "Written count exceeds the store depth.")
  `MAWR_ASSERT_NEXT(a_pos_step, cmd.capture, rd_addr_r == pos_r, "Window walk does not start at the newest entry.")

endmodule

// ----- tb/tb_moving_average_with_refill_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_with_refill_unit
// Self-checking testbench for the boxcar moving average with refill.
// ----------------------------------------------------------------------------
// The testbench drives sample requests through the valid/stall input channel
// and writes the window length between phases while the unit is idle. Each
// accepted request updates a local copy of the sample history, and the
// expected mean is queued. Every result taken from the output channel is
// compared with the oldest queued mean. Directed tests cover the reset
// state, field extremes, odd window settings, truncation toward zero, and
// whole-store refill. A long output hold-off fills the unit, and a long
// random phase with changing window lengths follows.
// ----------------------------------------------------------------------------
module tb_moving_average_with_refill_unit;
  import mawr_pkg::*;

  localparam int DEPTH = MAX_WINDOW_DEF;
  localparam int RANDOM_REQUESTS = 1650;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_W-1:0]           cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_restart;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_mean;

  logic signed [SAMPLE_W-1:0] sample_history [DEPTH];
  int                         newest_slot;
  logic [CFG_W-1:0]           window_setting;
  logic signed [SAMPLE_W-1:0] expected_means [$];
  logic signed [SAMPLE_W-1:0] oldest_mean;

  int requests_sent;
  int restarts_sent;
  int means_checked;
  int settings_written;
  int mismatch_count;
  int burst_left;
  int hold_off_request;

  moving_average_with_refill_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_restart  (in_restart),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_mean    (out_mean)
  );

  always #1 clk = ~clk;

  function automatic logic signed [SAMPLE_W-1:0] compute_window_mean(
      input logic restart, input logic signed [SAMPLE_W-1:0] sample);
    int     span;
    int     idx;
    longint window_sum;
    longint quotient;
    if (window_setting == 0) begin
      span = 1;
    end else if (window_setting > DEPTH) begin
      span = DEPTH;
    end else begin
      span = int'(window_setting);
    end
    newest_slot = (newest_slot + 1) % DEPTH;
    if (restart) begin
      foreach (sample_history[k]) sample_history[k] = sample;
    end else begin
      sample_history[newest_slot] = sample;
    end
    window_sum = 0;
    idx = newest_slot;
    for (int k = 0; k < span; k++) begin
      window_sum += sample_history[idx];
      idx = (idx == 0) ? DEPTH - 1 : idx - 1;
    end
    quotient = window_sum / span;
    return quotient[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 63) - 32);
      3: return 16'sh7FFF - 16'($urandom_range(0, 255));
      4: return 16'sh8000 + 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window_length();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'($urandom_range(65, 127));
      4, 5, 6: return 7'($urandom_range(2, 8));
      default: return 7'($urandom_range(9, 63));
    endcase
  endfunction

  task automatic send_sample(input logic restart, input logic signed [SAMPLE_W-1:0] sample);
    int gap;
    in_valid   <= 1'b1;
    in_restart <= restart;
    in_sample  <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_means.push_back(compute_window_mean(restart, sample));
    requests_sent++;
    if (restart) restarts_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window_length(input logic [CFG_W-1:0] len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_setting = len;
    settings_written++;
  endtask

  task automatic test_reset_state();
    send_sample(1'b0, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000);
    send_sample(1'b0, 16'sd5);
  endtask

  task automatic test_field_extremes();
    set_window_length(7'd1);
    send_sample(1'b0, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000);
    send_sample(1'b0, 16'sh0000);
    send_sample(1'b0, -16'sd1);
    send_sample(1'b0, 16'sh5555);
    send_sample(1'b0, 16'shAAAA);
  endtask

  task automatic test_window_limits();
    set_window_length(7'd0);
    send_sample(1'b0, -16'sd7);
    set_window_length(7'd127);
    send_sample(1'b1, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000);
    set_window_length(7'd65);
    send_sample(1'b0, 16'sh1234);
  endtask

  task automatic test_truncation();
    set_window_length(7'd3);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd0);
    set_window_length(7'd2);
    send_sample(1'b1, 16'sd5);
    send_sample(1'b0, -16'sd6);
  endtask

  task automatic test_restart_refill();
    set_window_length(7'd8);
    send_sample(1'b1, 16'sd1000);
    set_window_length(7'd64);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b1, 16'sh8000);
  endtask

  task automatic test_output_hold_off();
    set_window_length(7'd4);
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (6) send_sample(1'($urandom_range(0, 1)), random_sample());
  endtask

  task automatic test_random_windows();
    int   target;
    int   phase_items;
    bit   extremes_only;
    logic restart;
    logic signed [SAMPLE_W-1:0] sample;
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      set_window_length(pick_window_length());
      phase_items = $urandom_range(30, 150);
      if (phase_items > target - requests_sent) begin
        phase_items = target - requests_sent;
      end
      extremes_only = ($urandom_range(0, 5) == 0);
      repeat (phase_items) begin
        restart = ($urandom_range(0, 19) == 0);
        if (extremes_only) begin
          sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          sample = random_sample();
        end
        send_sample(restart, sample);
      end
    end
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_means.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_means.size() != 0) begin
      $error("mean: %0d expected results never arrived", expected_means.size());
      mismatch_count++;
    end
    repeat (120) @(posedge clk);
    $display("Sent %0d requests (%0d restarts) over %0d window length writes.",
             requests_sent, restarts_sent, settings_written);
    $display("Compared %0d means; %0d mismatches found.", means_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("mean: unexpected result, actual %0d", out_mean);
        mismatch_count++;
      end else begin
        oldest_mean = expected_means.pop_front();
        means_checked++;
        if (out_mean !== oldest_mean) begin
          $error("mean mismatch: expected %0d, actual %0d", oldest_mean, out_mean);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : receiver
    stall_mode_t stall_mode;
    int          mode_left;
    int          stall_phase;
    int          hold_len;
    out_stall = 1'b0;
    stall_mode = STALL_NONE;
    mode_left = 200;
    stall_phase = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_len = hold_off_request;
        hold_off_request = 0;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 300);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= ((stall_phase % 5) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    in_sample = '0;
    foreach (sample_history[k]) sample_history[k] = '0;
    newest_slot = 0;
    window_setting = WINDOW_RESET;
    requests_sent = 0;
    restarts_sent = 0;
    means_checked = 0;
    settings_written = 0;
    mismatch_count = 0;
    hold_off_request = 0;
    burst_left = $urandom_range(1, 24);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_field_extremes();
    test_window_limits();
    test_truncation();
    test_restart_refill();
    test_output_hold_off();
    test_random_windows();
    finish_run();
  end

endmodule
